[rtl/core/guard_zone_shadow_bitmap_unit_assert.svh]
// Assertion macros for the guard zone shadow bitmap unit.
// Included by files that check their own behavior; no other dependencies.
`ifndef GUARD_ZONE_SHADOW_BITMAP_UNIT_ASSERT_SVH
`define GUARD_ZONE_SHADOW_BITMAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GZSB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define GZSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GZSB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define GZSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/gzsb_pkg.sv]
// Shared types and constants of the guard zone shadow bitmap unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package gzsb_pkg;

    localparam int RUN_BITS      = 16;
    localparam int CNT_BITS      = RUN_BITS - 3;
    localparam int OUT_W         = 24;
    localparam int OUT_PAD       = OUT_W - RUN_BITS - 4;
    localparam int WORD_GRANULES = 64;

    localparam logic [RUN_BITS-1:0] LIMIT_RESET = 16'hFFF8;

    typedef enum logic [1:0] {
        MODE_MARK    = 2'd0,
        MODE_UNMARK  = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_MEASURE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MRD,
        S_MWR,
        S_QRD,
        S_QEV,
        S_RRD,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic ld_req;
        logic mem_rd;
        logic mark_wr;
        logic query_cap;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_mode in_op;
        logic  in_trivial;
        logic  clr_last;
        logic  mark_last;
        logic  scan_done;
        logic  scan_next_word;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/gzsb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the shadow bitmap words.
`default_nettype none

module gzsb_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 2048,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/gzsb_ctrl.sv]
// Controller state machine of the guard zone shadow bitmap unit.
// Depends on gzsb_pkg; drives the datapath by command and reads its status.
`default_nettype none

module gzsb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gzsb_pkg::t_sts i_sts,
    output gzsb_pkg::t_cmd     o_cmd
);

    import gzsb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_req = 1'b1;
                    if (i_sts.in_trivial) begin
                        n_state = S_DONE;
                    end else if (i_sts.in_op inside {MODE_MARK, MODE_UNMARK}) begin
                        n_state = S_MRD;
                    end else if (i_sts.in_op == MODE_QUERY) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_RRD;
                    end
                end
            end
            S_MRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_MWR;
            end
            S_MWR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = i_sts.mark_last ? S_DONE : S_MRD;
            end
            S_QRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_QEV;
            end
            S_QEV: begin
                o_cmd.query_cap = 1'b1;
                n_state         = S_DONE;
            end
            S_RRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_next_word) begin
                    n_state = S_RRD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/gzsb_dpath.sv]
// Datapath of the guard zone shadow bitmap unit: request decode, word
// read-modify-write, run scan, limit register and result register.
// Depends on gzsb_pkg and gzsb_ram.
`default_nettype none

module gzsb_dpath #(
    parameter int  ADDR_BITS     = 20,
    parameter int  LEN_BITS      = 16,
    localparam int IN_W          = ((2 + ADDR_BITS + LEN_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gzsb_pkg::t_cmd                  i_cmd,
    output gzsb_pkg::t_sts                       o_sts,
    input  wire logic [IN_W-1:0]                 i_in_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [gzsb_pkg::RUN_BITS-1:0]   i_cfg_wdata,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [gzsb_pkg::OUT_W-1:0]      o_out_data
);

    import gzsb_pkg::*;

    localparam int WG_BITS   = $clog2(WORD_GRANULES);
    localparam int GRAN_BITS = ADDR_BITS - 3;
    localparam int WORD_BITS = GRAN_BITS - WG_BITS;
    localparam int DEPTH     = 1 << WORD_BITS;
    localparam int REM_BITS  = LEN_BITS - 3;
    localparam int SPAN_BITS = WG_BITS + 1;
    localparam int RW        = (REM_BITS > SPAN_BITS) ? REM_BITS : SPAN_BITS;
    localparam int SUM_BITS  = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
    localparam logic [SUM_BITS-1:0] SPACE = {{(SUM_BITS-1){1'b0}}, 1'b1} << ADDR_BITS;

    t_mode                  in_mode;
    logic [ADDR_BITS-1:0]   in_addr;
    logic [LEN_BITS-1:0]    in_len;
    logic [GRAN_BITS-1:0]   in_gran;
    logic [SUM_BITS-1:0]    in_sum;
    t_status                in_status;
    logic [CNT_BITS-1:0]    in_limg;

    t_mode                  r_op;
    t_status                r_status;
    logic                   r_zone;
    logic [WORD_BITS-1:0]   r_word;
    logic [WG_BITS-1:0]     r_bit;
    logic [REM_BITS-1:0]    r_remain;
    logic [GRAN_BITS-1:0]   r_gran;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    r_limg;
    logic [WORD_BITS-1:0]   r_clr;
    logic [RUN_BITS-1:0]    r_limit;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic                   r_out_zone;
    logic [RUN_BITS-1:0]    r_out_run;
    logic                   r_out_capped;

    logic [WORD_GRANULES-1:0] mem_rdata;
    logic [WORD_GRANULES-1:0] mem_wdata;
    logic [WORD_BITS-1:0]     mem_waddr;
    logic [WORD_BITS-1:0]     mem_raddr;
    logic                     mem_we;

    logic [SPAN_BITS-1:0]     avail;
    logic [RW-1:0]            take_x;
    logic [SPAN_BITS-1:0]     take;
    logic [SPAN_BITS-1:0]     m_end;
    logic [WORD_GRANULES-1:0] m_mask;
    logic [WORD_GRANULES-1:0] m_wdata;

    logic [GRAN_BITS-1:0]     gm1;
    logic [WG_BITS-1:0]       pos;
    logic [SPAN_BITS-1:0]     span;
    logic [CNT_BITS-1:0]      need;
    logic [WORD_GRANULES-1:0] low_mask;
    logic                     full;
    logic                     jump;
    logic                     hit;
    logic [SPAN_BITS-1:0]     step;
    logic [CNT_BITS-1:0]      cnt_next;
    logic [GRAN_BITS-1:0]     gran_next;

    assign in_mode = t_mode'(i_in_data[1:0]);
    assign in_addr = i_in_data[ADDR_BITS+1:2];
    assign in_len  = i_in_data[ADDR_BITS+LEN_BITS+1:ADDR_BITS+2];
    assign in_gran = in_addr[ADDR_BITS-1:3];
    assign in_sum  = SUM_BITS'(in_addr) + SUM_BITS'(in_len);

    always_comb begin
        in_status = ST_OK;
        case (in_mode)
            MODE_MARK, MODE_UNMARK: begin
                if (in_len[2:0] != 3'd0) begin
                    in_status = ST_BAD_LEN;
                end else if (in_addr[2:0] != 3'd0) begin
                    in_status = ST_MISALIGN;
                end else if (in_sum > SPACE) begin
                    in_status = ST_RANGE;
                end
            end
            MODE_MEASURE: begin
                if (in_addr[2:0] != 3'd0) begin
                    in_status = ST_MISALIGN;
                end
            end
            default: begin
                in_status = ST_OK;
            end
        endcase
    end

    assign in_limg = (r_limit[RUN_BITS-1:3] == '0) ? CNT_BITS'(1) : r_limit[RUN_BITS-1:3];

    assign avail  = SPAN_BITS'(WORD_GRANULES) - SPAN_BITS'(r_bit);
    assign take_x = (RW'(r_remain) < RW'(avail)) ? RW'(r_remain) : RW'(avail);
    assign take   = SPAN_BITS'(take_x);
    assign m_end  = SPAN_BITS'(r_bit) + take;

    always_comb begin
        for (int i = 0; i < WORD_GRANULES; i++) begin
            m_mask[i]   = (SPAN_BITS'(i) >= SPAN_BITS'(r_bit)) && (SPAN_BITS'(i) < m_end);
            low_mask[i] = SPAN_BITS'(i) <= SPAN_BITS'(pos);
        end
    end

    assign m_wdata = (r_op == MODE_MARK) ? (mem_rdata | m_mask) : (mem_rdata & ~m_mask);

    assign gm1       = r_gran - GRAN_BITS'(1);
    assign pos       = gm1[WG_BITS-1:0];
    assign span      = SPAN_BITS'(pos) + SPAN_BITS'(1);
    assign need      = r_limg - r_count;
    assign full      = &(mem_rdata | ~low_mask);
    assign jump      = full && (CNT_BITS'(span) <= need);
    assign hit       = jump || mem_rdata[pos];
    assign step      = jump ? span : SPAN_BITS'(1);
    assign cnt_next  = r_count + CNT_BITS'(step);
    assign gran_next = r_gran - GRAN_BITS'(step);

    assign mem_we    = i_cmd.clr_step || i_cmd.mark_wr;
    assign mem_waddr = i_cmd.clr_step ? r_clr : r_word;
    assign mem_wdata = i_cmd.clr_step ? '0 : m_wdata;
    assign mem_raddr = (r_op == MODE_MEASURE) ? gm1[GRAN_BITS-1:WG_BITS] : r_word;

    gzsb_ram #(
        .WIDTH (WORD_GRANULES),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + WORD_BITS'(1);
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_op     <= in_mode;
            r_status <= in_status;
            r_zone   <= 1'b0;
            r_count  <= '0;
            r_limg   <= in_limg;
            r_word   <= in_gran[GRAN_BITS-1:WG_BITS];
            r_bit    <= in_gran[WG_BITS-1:0];
            r_remain <= in_len[LEN_BITS-1:3];
            r_gran   <= in_gran;
        end
        if (i_cmd.mark_wr) begin
            r_remain <= r_remain - REM_BITS'(take_x);
            r_word   <= r_word + WORD_BITS'(1);
            r_bit    <= '0;
        end
        if (i_cmd.query_cap) begin
            r_zone <= mem_rdata[r_bit];
        end
        if (i_cmd.scan_step && hit) begin
            r_count <= cnt_next;
            r_gran  <= gran_next;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_zone   <= r_zone;
            r_out_run    <= (r_op == MODE_MEASURE) ? {r_count, 3'b000} : '0;
            r_out_capped <= (r_op == MODE_MEASURE) && (r_status == ST_OK)
                            && (r_count >= r_limg);
        end
    end

    always_comb begin
        o_sts                = '0;
        o_sts.in_op          = in_mode;
        o_sts.in_trivial     = (in_status != ST_OK)
                               || ((in_mode inside {MODE_MARK, MODE_UNMARK})
                                   && (in_len[LEN_BITS-1:3] == '0))
                               || ((in_mode == MODE_MEASURE) && (in_gran == '0));
        o_sts.clr_last       = &r_clr;
        o_sts.mark_last      = RW'(r_remain) == take_x;
        o_sts.scan_done      = !hit || (cnt_next >= r_limg) || (gran_next == '0);
        o_sts.scan_next_word = jump || (pos == '0);
        o_sts.out_free       = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{OUT_PAD{1'b0}}, r_out_capped, r_out_run, r_out_zone, r_out_status};

endmodule

`default_nettype wire

[rtl/core/guard_zone_shadow_bitmap_unit.sv]
// Top level of the guard zone shadow bitmap unit.
// Depends on gzsb_pkg, gzsb_ctrl, gzsb_dpath and the assertion macro header.
//
// Requests enter on the s_axis channel: mode, byte address and length. Each
// request gives one result on the m_axis channel: status, in-zone flag, run
// length in bytes and a capped flag. The user must write the run limit through
// i_cfg_we and i_cfg_wdata only while no request is in flight; the block itself
// does not enforce this. The block works on one request at a time. With a
// ready receiver the result becomes valid in the same cycle as the next request
// can be taken. A query reads its bitmap word and then takes the addressed bit.
// Mark and unmark read and write back each bitmap word touched in turn; bad
// requests, empty ranges and a measure at address 0 go straight to the result.
// A measure reads each word that the run crosses in one step and crosses it,
// then reads the word where the scan stops and tests its granules one by one.
// After reset a clearing pass zeroes all 2^(ADDR_BITS-3)/WORD_GRANULES bitmap
// words (2048 by default), one word a cycle; no request is taken meanwhile.
// The result sits in an output register, so a stalled receiver does not stop
// the next request from being accepted and worked on; that request waits for
// the register to free before it delivers its result.
`default_nettype none
`include "guard_zone_shadow_bitmap_unit_assert.svh"

module guard_zone_shadow_bitmap_unit #(
    parameter int  ADDR_BITS     = 20,
    parameter int  LEN_BITS      = 16,
    localparam int IN_W          = ((2 + ADDR_BITS + LEN_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0: mode, byte_address, length_bytes, zero fill.
    input  wire logic [IN_W-1:0]               i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // Fields from bit 0: status, in_zone, run_bytes, run_capped, zero fill.
    output logic      [gzsb_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [gzsb_pkg::RUN_BITS-1:0] i_cfg_wdata
);

    import gzsb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gzsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gzsb_dpath #(
        .ADDR_BITS     (ADDR_BITS),
        .LEN_BITS      (LEN_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    `GZSB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
        "request accepted while another was in flight")
    `GZSB_ASSERT_SAME(a_error_fields_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK), o_m_axis_tdata[OUT_W-1:2] == '0,
        "error result carries nonzero fields")
    `GZSB_ASSERT_SAME(a_capped_has_run, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[RUN_BITS+3], o_m_axis_tdata[RUN_BITS+2:3] != '0,
        "capped run with zero length")

endmodule

`default_nettype wire
